### rtl/ham_pixel_encoder_assert.svh
// Assertion macros shared by the ham_pixel_encoder checkers.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef HAM_PIXEL_ENCODER_ASSERT_SVH
`define HAM_PIXEL_ENCODER_ASSERT_SVH

// same-cycle implication, masked during reset
`define HAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define HAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks the reset behavior itself
`define HAM_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hamenc_pkg.sv
// Shared types and constants for the hold-and-modify pixel encoder.
// No dependencies; imported by hamenc_pick, ham_pixel_encoder, hamenc_chk and the testbench.
`timescale 1ns / 1ps

package hamenc_pkg;

  localparam int CHAN_W      = 4;
  localparam int NUM_GROUPS  = 4;
  localparam int GROUP_IDX_W = 2;
  localparam int ENTRY_W     = 3 * CHAN_W;
  localparam int PER_GROUP   = 4;
  localparam int GROUP_W     = PER_GROUP * ENTRY_W;
  localparam int NUM_ENTRIES = NUM_GROUPS * PER_GROUP;
  localparam int ENTRY_IDX_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CODE_W      = 6;
  localparam int ERR_W       = 5;
  localparam int DIST_W      = 6;

  // upper two bits of a code: palette index or which channel is modified
  localparam logic [1:0] CODE_PALETTE    = 2'b00;
  localparam logic [1:0] CODE_MOD_BLUE   = 2'b01;
  localparam logic [1:0] CODE_MOD_RED    = 2'b10;
  localparam logic [1:0] CODE_MOD_GREEN  = 2'b11;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] palette_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    rgb_t              held;
  } pick_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/hamenc_pick.sv
// Combinational code pick: modify choice plus 16-entry palette search.
// Depends on hamenc_pkg.
`timescale 1ns / 1ps

module hamenc_pick (
  input  hamenc_pkg::rgb_t     pix,
  input  logic                 line_start,
  input  hamenc_pkg::rgb_t     held,
  input  hamenc_pkg::palette_t palette,
  output hamenc_pkg::pick_t    res
);
  import hamenc_pkg::*;

  rgb_t                   base;
  rgb_t                   mod_held;
  logic [CHAN_W-1:0]      dr, dg, db;
  logic [ERR_W-1:0]       err;
  logic [CODE_W-1:0]      mod_code;
  rgb_t                   entry [NUM_ENTRIES];
  logic [DIST_W-1:0]      pix_dist [NUM_ENTRIES];
  logic [DIST_W-1:0]      d8 [8];
  logic [ENTRY_IDX_W-1:0] i8 [8];
  logic [DIST_W-1:0]      d4 [4];
  logic [ENTRY_IDX_W-1:0] i4 [4];
  logic [DIST_W-1:0]      d2 [2];
  logic [ENTRY_IDX_W-1:0] i2 [2];
  logic [DIST_W-1:0]      min_d;
  logic [ENTRY_IDX_W-1:0] min_i;
  logic                   hit;

  always_comb begin
    base = line_start ? '0 : held;
    dr   = abs_diff(pix.red,   base.red);
    dg   = abs_diff(pix.green, base.green);
    db   = abs_diff(pix.blue,  base.blue);
    mod_held = base;
    if (dr > dg && dr > db) begin
      mod_held.red = pix.red;
      mod_code     = {CODE_MOD_RED, pix.red};
      err          = {1'b0, dg} + {1'b0, db};
    end else if (dg > db) begin
      mod_held.green = pix.green;
      mod_code       = {CODE_MOD_GREEN, pix.green};
      err            = {1'b0, dr} + {1'b0, db};
    end else begin
      mod_held.blue = pix.blue;
      mod_code      = {CODE_MOD_BLUE, pix.blue};
      err           = {1'b0, dg} + {1'b0, dr};
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      entry[k] = rgb_t'(palette[k / PER_GROUP][(k % PER_GROUP) * ENTRY_W +: ENTRY_W]);
      pix_dist[k] = DIST_W'(abs_diff(entry[k].red,   pix.red))
                  + DIST_W'(abs_diff(entry[k].green, pix.green))
                  + DIST_W'(abs_diff(entry[k].blue,  pix.blue));
    end
  end

  // min tree; the lower index keeps ties, matching a first-strictly-better scan
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (pix_dist[2*k+1] < pix_dist[2*k]) begin
        d8[k] = pix_dist[2*k+1];
        i8[k] = ENTRY_IDX_W'(2*k+1);
      end else begin
        d8[k] = pix_dist[2*k];
        i8[k] = ENTRY_IDX_W'(2*k);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (d8[2*k+1] < d8[2*k]) begin
        d4[k] = d8[2*k+1];
        i4[k] = i8[2*k+1];
      end else begin
        d4[k] = d8[2*k];
        i4[k] = i8[2*k];
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (d4[2*k+1] < d4[2*k]) begin
        d2[k] = d4[2*k+1];
        i2[k] = i4[2*k+1];
      end else begin
        d2[k] = d4[2*k];
        i2[k] = i4[2*k];
      end
    end
    if (d2[1] < d2[0]) begin
      min_d = d2[1];
      min_i = i2[1];
    end else begin
      min_d = d2[0];
      min_i = i2[0];
    end
  end

  // a zero modify error never loses to the palette, so no separate check
  assign hit = min_d < {1'b0, err};

  always_comb begin
    if (hit) begin
      res.code = {CODE_PALETTE, min_i};
      res.held = entry[min_i];
    end else begin
      res.code = mod_code;
      res.held = mod_held;
    end
  end

endmodule

### rtl/ham_pixel_encoder.sv
// Hold-and-modify pixel encoder top level: pixel input register, code pick,
// code output register and palette registers. Depends on hamenc_pkg, hamenc_pick.
//
// Usage:
//   Input channel in_*: one RGB pixel (4 bits per channel) plus line_start,
//   which clears the held colour before the pixel is encoded.
//   Output channel out_*: one 6-bit code per pixel, in order.
//   Configuration port cfg_*: cfg_index 0..3 writes palette group 0..3
//   (four 12-bit r/g/b entries each); higher indexes are ignored. Write only
//   while no pixel is in flight.
//   Pipeline: a pixel passes the input register, then the code register, before
//   out_valid rises; a stall on out_ready can keep it in the input register.
//   Throughput: one pixel per cycle while out_ready stays high; the held colour
//   update and the 16 palette distance compares all fit in the single
//   combinational pass between the two registers.
//   Stalls: with out_ready low the code register holds; one more pixel can
//   wait in the input register, after which in_ready drops.
//   Reset: synchronous, active low; clears both valid flags, the held colour
//   and all palette entries.
`timescale 1ns / 1ps

module ham_pixel_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hamenc_pkg::CHAN_W-1:0]       in_pixel_red,
  input  logic [hamenc_pkg::CHAN_W-1:0]       in_pixel_green,
  input  logic [hamenc_pkg::CHAN_W-1:0]       in_pixel_blue,
  input  logic                                in_line_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hamenc_pkg::CODE_W-1:0]       out_ham_code,
  input  logic                                cfg_we,
  input  logic [hamenc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hamenc_pkg::GROUP_W-1:0]      cfg_wdata
);
  import hamenc_pkg::*;

  palette_t          pal_r, pal_nxt;
  logic              in_vld_r, in_vld_nxt;
  rgb_t              pix_r;
  logic              ls_r;
  rgb_t              held_r;
  logic              out_vld_r, out_vld_nxt;
  logic [CODE_W-1:0] code_r;
  logic              adv;
  logic              take;
  pick_t             pick;

  assign adv  = in_vld_r && (!out_vld_r || out_ready);
  assign take = in_valid && in_ready;

  assign in_ready     = !in_vld_r || adv;
  assign out_valid    = out_vld_r;
  assign out_ham_code = code_r;

  hamenc_pick u_pick (
    .pix        (pix_r),
    .line_start (ls_r),
    .held       (held_r),
    .palette    (pal_r),
    .res        (pick)
  );

  always_comb begin
    pal_nxt = pal_r;
    if (cfg_we && cfg_index < CFG_IDX_W'(NUM_GROUPS)) begin
      pal_nxt[cfg_index[GROUP_IDX_W-1:0]] = cfg_wdata;
    end
    in_vld_nxt  = take || (in_vld_r && !adv);
    out_vld_nxt = adv || (out_vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r     <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      held_r    <= '0;
    end else begin
      pal_r     <= pal_nxt;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        held_r <= pick.held;
      end
    end
  end

  // payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (take) begin
      pix_r <= '{red: in_pixel_red, green: in_pixel_green, blue: in_pixel_blue};
      ls_r  <= in_line_start;
    end
    if (adv) begin
      code_r <= pick.code;
    end
  end

endmodule

### rtl/hamenc_chk.sv
// Port-level checker for ham_pixel_encoder, attached by bind.
// Depends on hamenc_pkg and ham_pixel_encoder_assert.svh.
`timescale 1ns / 1ps
`include "ham_pixel_encoder_assert.svh"

module hamenc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hamenc_pkg::CODE_W-1:0] out_ham_code
);
  import hamenc_pkg::*;

  `HAM_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid, "out_valid after reset")
  `HAM_ASSERT_NOW(a_ready_when_drained, !out_valid || out_ready, in_ready, "in_ready low without stall")
  `HAM_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready, out_valid, "result missing two cycles after transfer")
  `HAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ham_code), "stalled result changed")

endmodule

bind ham_pixel_encoder hamenc_chk u_hamenc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_ham_code (out_ham_code)
);

### test/ham_pixel_encoder_tb.sv
// Self-checking testbench for ham_pixel_encoder: directed pixels, then random
// pixel streams over several palettes, with random stalls on both channels.
// Depends on hamenc_pkg and the ham_pixel_encoder RTL.
`timescale 1ns / 1ps

module ham_pixel_encoder_tb;
  import hamenc_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 64;
  localparam int IDLE_PCT        = 12;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int LIMIT_CYCLES    = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_PAL_GROUP0 = 3'd0;

  typedef struct packed {
    rgb_t              colour;
    logic              line_start;
    logic              fixed;
    logic [CODE_W-1:0] code;
  } stim_row_t;

  // Palette is all zero here; typed codes follow from reset state.
  localparam stim_row_t DIRECTED_ROWS [18] = '{
    '{'{4'd0,  4'd0,  4'd0 }, 1'b0, 1'b1, {CODE_MOD_BLUE,  4'h0}},
    '{'{4'd15, 4'd0,  4'd0 }, 1'b0, 1'b1, {CODE_MOD_RED,   4'hF}},
    '{'{4'd15, 4'd15, 4'd0 }, 1'b0, 1'b1, {CODE_MOD_GREEN, 4'hF}},
    '{'{4'd15, 4'd15, 4'd15}, 1'b0, 1'b1, {CODE_MOD_BLUE,  4'hF}},
    // large miss, palette entry zero is much closer
    '{'{4'd1,  4'd1,  4'd0 }, 1'b0, 1'b1, {CODE_PALETTE,   4'h0}},
    // three-way tie goes to blue, palette no closer
    '{'{4'd15, 4'd15, 4'd15}, 1'b1, 1'b1, {CODE_MOD_BLUE,  4'hF}},
    // red and green tie goes to green
    '{'{4'd5,  4'd5,  4'd0 }, 1'b1, 1'b1, {CODE_MOD_GREEN, 4'h5}},
    // green and blue tie goes to blue
    '{'{4'd0,  4'd7,  4'd7 }, 1'b1, 1'b1, {CODE_MOD_BLUE,  4'h7}},
    '{'{4'd9,  4'd3,  4'd0 }, 1'b1, 1'b1, {CODE_MOD_RED,   4'h9}},
    '{'{4'd9,  4'd0,  4'd0 }, 1'b0, 1'b1, {CODE_MOD_BLUE,  4'h0}},
    '{'{4'd0,  4'd0,  4'd0 }, 1'b0, 1'b1, {CODE_MOD_RED,   4'h0}},
    '{'{4'd10, 4'd5,  4'd3 }, 1'b0, 1'b0, {CODE_PALETTE,   4'h0}},
    '{'{4'd3,  4'd12, 4'd7 }, 1'b0, 1'b0, {CODE_PALETTE,   4'h0}},
    '{'{4'd8,  4'd8,  4'd8 }, 1'b1, 1'b0, {CODE_PALETTE,   4'h0}},
    '{'{4'd6,  4'd2,  4'd14}, 1'b0, 1'b0, {CODE_PALETTE,   4'h0}},
    '{'{4'd14, 4'd1,  4'd9 }, 1'b0, 1'b0, {CODE_PALETTE,   4'h0}},
    '{'{4'd2,  4'd2,  4'd2 }, 1'b0, 1'b0, {CODE_PALETTE,   4'h0}},
    '{'{4'd7,  4'd0,  4'd13}, 1'b1, 1'b0, {CODE_PALETTE,   4'h0}}
  };

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_pixel_red   = '0;
  logic [CHAN_W-1:0]    in_pixel_green = '0;
  logic [CHAN_W-1:0]    in_pixel_blue  = '0;
  logic                 in_line_start  = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [CODE_W-1:0]    out_ham_code;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [GROUP_W-1:0]   cfg_wdata      = '0;

  palette_t          pal_mirror  = '0;
  rgb_t              held_colour = '0;
  logic [CODE_W-1:0] expected_codes [$];
  int                mismatches  = 0;
  int                tx_idle_pct = IDLE_PCT;
  int                rx_idle_pct = IDLE_PCT;
  logic              hold_req    = 1'b0;

  ham_pixel_encoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .in_line_start  (in_line_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ham_code   (out_ham_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int chan_dist(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic rgb_t palette_entry(input int k);
    return pal_mirror[k / PER_GROUP][(k % PER_GROUP) * ENTRY_W +: ENTRY_W];
  endfunction

  // Encode one pixel and advance the held colour.
  function automatic logic [CODE_W-1:0] encode_pixel(input rgb_t px, input logic line_start);
    int                d_red, d_green, d_blue, best, ent_dist;
    logic [CODE_W-1:0] code;
    rgb_t              ent;
    if (line_start) held_colour = '0;
    d_red   = chan_dist(px.red,   held_colour.red);
    d_green = chan_dist(px.green, held_colour.green);
    d_blue  = chan_dist(px.blue,  held_colour.blue);
    if (d_red > d_green && d_red > d_blue) begin
      held_colour.red = px.red;
      code = {CODE_MOD_RED, px.red};
      best = d_green + d_blue;
    end else if (d_green >= d_red && d_green > d_blue) begin
      held_colour.green = px.green;
      code = {CODE_MOD_GREEN, px.green};
      best = d_red + d_blue;
    end else begin
      held_colour.blue = px.blue;
      code = {CODE_MOD_BLUE, px.blue};
      best = d_red + d_green;
    end
    if (best != 0) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        ent      = palette_entry(k);
        ent_dist = chan_dist(ent.red, px.red) + chan_dist(ent.green, px.green) +
                   chan_dist(ent.blue, px.blue);
        // strict compare keeps the lowest-numbered entry on a tie
        if (ent_dist < best) begin
          best        = ent_dist;
          code        = {CODE_PALETTE, ENTRY_IDX_W'(k)};
          held_colour = ent;
        end
      end
    end
    return code;
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v);
    int t;
    t = v;
    t = t + int'($urandom_range(4)) - 2;
    if (t < 0) t = 0;
    if (t > 15) t = 15;
    return CHAN_W'(t);
  endfunction

  // Mix of near-held, near-palette, extreme, single-channel and fully random pixels.
  function automatic rgb_t random_colour();
    rgb_t c;
    int   kind;
    kind = $urandom_range(99);
    c    = ENTRY_W'($urandom);
    if (kind < 25) begin
      c       = held_colour;
      c.red   = nudge(c.red);
      c.green = nudge(c.green);
      c.blue  = nudge(c.blue);
    end else if (kind < 40) begin
      c = palette_entry($urandom_range(NUM_ENTRIES - 1));
      case ($urandom_range(2))
        0:       c.red   = nudge(c.red);
        1:       c.green = nudge(c.green);
        default: c.blue  = nudge(c.blue);
      endcase
    end else if (kind < 50) begin
      c.red   = $urandom_range(1) ? '1 : '0;
      c.green = $urandom_range(1) ? '1 : '0;
      c.blue  = $urandom_range(1) ? '1 : '0;
    end else if (kind < 60) begin
      // one channel moves only: zero modify error
      c = held_colour;
      case ($urandom_range(2))
        0:       c.red   = CHAN_W'($urandom);
        1:       c.green = CHAN_W'($urandom);
        default: c.blue  = CHAN_W'($urandom);
      endcase
    end
    return c;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_code(input logic [CODE_W-1:0] got);
    logic [CODE_W-1:0] want;
    if (expected_codes.size() == 0) begin
      report($sformatf("ham_code %02h with nothing pending", got));
    end else begin
      want = expected_codes.pop_front();
      if (got !== want) report($sformatf("ham_code got %02h want %02h", got, want));
    end
  endtask

  task automatic send_pixel(input rgb_t colour, input logic line_start, input logic fixed,
                            input logic [CODE_W-1:0] fixed_code);
    logic [CODE_W-1:0] predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_red   <= colour.red;
    in_pixel_green <= colour.green;
    in_pixel_blue  <= colour.blue;
    in_line_start  <= line_start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = encode_pixel(colour, line_start);
    expected_codes.push_back(fixed ? fixed_code : predicted);
  endtask

  task automatic wait_drained();
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group(input logic [CFG_IDX_W-1:0] idx, input logic [GROUP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx < NUM_GROUPS) pal_mirror[idx[GROUP_IDX_W-1:0]] = data;
    @(posedge clk);
  endtask

  task automatic load_palette(input int ph);
    logic [GROUP_W-1:0] grp;
    logic [CHAN_W-1:0]  lad;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp = '0;
      case (ph)
        0: grp = '1;
        1: begin
          for (int k = 0; k < PER_GROUP; k++) begin
            lad = CHAN_W'(g * PER_GROUP + k);
            grp[k * ENTRY_W +: ENTRY_W] = {lad, ~lad, lad ^ 4'h5};
          end
        end
        2: grp = '0;
        default: begin
          // copy earlier entries now and then so distances tie
          for (int k = 0; k < PER_GROUP; k++) begin
            if (k != 0 && $urandom_range(2) == 0)
              grp[k * ENTRY_W +: ENTRY_W] = grp[$urandom_range(k - 1) * ENTRY_W +: ENTRY_W];
            else
              grp[k * ENTRY_W +: ENTRY_W] = ENTRY_W'($urandom);
          end
        end
      endcase
      if (ph < 3 || $urandom_range(3) != 0)
        write_group(CFG_IDX_W'(REG_PAL_GROUP0 + g), grp);
    end
    // indexes past the last group must leave the palette alone
    if (ph == 0 || ph == 5) begin
      for (int i = NUM_GROUPS; i < (1 << CFG_IDX_W); i++)
        write_group(CFG_IDX_W'(i), GROUP_W'({$urandom, $urandom}));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
        if (out_valid && out_ready) check_code(out_ham_code);
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i])
      send_pixel(DIRECTED_ROWS[i].colour, DIRECTED_ROWS[i].line_start,
                 DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].code);
    in_valid <= 1'b0;
    wait_drained();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_palette(ph);
      tx_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
      rx_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((ph == 3 || ph == 6) && n == ITEMS_PER_PHASE / 2) hold_req = 1'b1;
        send_pixel(random_colour(), $urandom_range(9) == 0, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
